// ===== rtl/core/dewsel_pkg.sv =====
package dewsel_pkg;

	localparam int NUM_CH = 6;
	localparam int TIME_W = 16;
	localparam int AMP_W = 12;
	localparam int QUO_W = 8;
	localparam int DVS_W = AMP_W + QUO_W - 1;
	localparam int DIV_STAGES = 4;
	localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [15:0] WALK_RESET = 16'd13000;
	localparam logic [15:0] TMIN_RESET = 16'd900;
	localparam logic signed [19:0] DLOW_RESET = 20'sd0;
	localparam logic signed [19:0] DHIGH_RESET = 20'sd0;
	localparam logic signed [10:0] OFFSET_RESET = 11'sd78;
	localparam logic [9:0] HALFWIDTH_RESET = 10'd20;

	localparam logic [AMP_W-1:0] AMP_LO [NUM_CH] = '{12'd600, 12'd600, 12'd500,
		12'd500, 12'd400, 12'd400};
	localparam logic [AMP_W-1:0] AMP_HI [NUM_CH] = '{12'd1200, 12'd1200, 12'd1200,
		12'd1200, 12'd1200, 12'd1100};

	typedef enum logic [2:0] {
		REG_WALK      = 3'd0,
		REG_TMIN      = 3'd1,
		REG_DLOW      = 3'd2,
		REG_DHIGH     = 3'd3,
		REG_OFFSET    = 3'd4,
		REG_HALFWIDTH = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        walk_constant;
		logic [15:0]        time_minimum;
		logic signed [19:0] delta_low_q;
		logic signed [19:0] delta_high_q;
		logic signed [10:0] outer_offset_h;
		logic [9:0]         outer_halfwidth_h;
	} cfg_t;

	typedef struct packed {
		logic                              time_ok;
		logic                              amp_ok;
		logic [NUM_CH-1:0][TIME_W-1:0]     t;
		logic [NUM_CH-1:0][TIME_W-1:0]     rem;
		logic [NUM_CH-1:0][DVS_W-1:0]      dvs;
		logic [NUM_CH-1:0][QUO_W-1:0]      q;
	} div_item_t;

endpackage

// ===== rtl/core/dewsel_cfg.sv =====
module dewsel_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dewsel_pkg::ADDR_W-1:0]  paddr,
	input  logic [dewsel_pkg::DATA_W-1:0]  pwdata,
	output logic [dewsel_pkg::DATA_W-1:0]  prdata,
	output logic                           pready,
	output dewsel_pkg::cfg_t               cfg
);

	dewsel_pkg::cfg_t cfg_q;
	logic             wr_en;
	logic [2:0]       idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.walk_constant <= dewsel_pkg::WALK_RESET;
			cfg_q.time_minimum <= dewsel_pkg::TMIN_RESET;
			cfg_q.delta_low_q <= dewsel_pkg::DLOW_RESET;
			cfg_q.delta_high_q <= dewsel_pkg::DHIGH_RESET;
			cfg_q.outer_offset_h <= dewsel_pkg::OFFSET_RESET;
			cfg_q.outer_halfwidth_h <= dewsel_pkg::HALFWIDTH_RESET;
		end else if (wr_en) begin
			case (idx)
				dewsel_pkg::REG_WALK:      cfg_q.walk_constant <= pwdata[15:0];
				dewsel_pkg::REG_TMIN:      cfg_q.time_minimum <= pwdata[15:0];
				dewsel_pkg::REG_DLOW:      cfg_q.delta_low_q <= pwdata[19:0];
				dewsel_pkg::REG_DHIGH:     cfg_q.delta_high_q <= pwdata[19:0];
				dewsel_pkg::REG_OFFSET:    cfg_q.outer_offset_h <= pwdata[10:0];
				dewsel_pkg::REG_HALFWIDTH: cfg_q.outer_halfwidth_h <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dewsel_pkg::REG_WALK:      prdata = {16'd0, cfg_q.walk_constant};
			dewsel_pkg::REG_TMIN:      prdata = {16'd0, cfg_q.time_minimum};
			dewsel_pkg::REG_DLOW:      prdata = {12'd0, cfg_q.delta_low_q};
			dewsel_pkg::REG_DHIGH:     prdata = {12'd0, cfg_q.delta_high_q};
			dewsel_pkg::REG_OFFSET:    prdata = {21'd0, cfg_q.outer_offset_h};
			dewsel_pkg::REG_HALFWIDTH: prdata = {22'd0, cfg_q.outer_halfwidth_h};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/dewsel_check.sv =====
module dewsel_check (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  valid,
	output logic                                                  stall,
	input  logic [dewsel_pkg::NUM_CH-1:0][dewsel_pkg::TIME_W-1:0] t,
	input  logic [dewsel_pkg::NUM_CH-1:0][dewsel_pkg::AMP_W-1:0]  a,
	input  dewsel_pkg::cfg_t                                      cfg,
	output logic                                                  valid_s1,
	input  logic                                                  stall_next,
	output dewsel_pkg::div_item_t                                 item_s1
);

	dewsel_pkg::div_item_t nxt;

	assign stall = valid_s1 & stall_next;

	always_comb begin
		nxt.time_ok = 1'b1;
		nxt.amp_ok = 1'b1;
		for (int i = 0; i < dewsel_pkg::NUM_CH; i++) begin
			if (!(t[i] > cfg.time_minimum))
				nxt.time_ok = 1'b0;
			if (!(a[i] > dewsel_pkg::AMP_LO[i] && a[i] < dewsel_pkg::AMP_HI[i]))
				nxt.amp_ok = 1'b0;
			nxt.t[i] = t[i];
			nxt.rem[i] = cfg.walk_constant;
			nxt.dvs[i] = {a[i], {(dewsel_pkg::QUO_W-1){1'b0}}};
			nxt.q[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!stall)
			valid_s1 <= valid;
	end

	always_ff @(posedge clk) begin
		if (!stall && valid)
			item_s1 <= nxt;
	end

endmodule

// ===== rtl/core/dewsel_divider.sv =====
module dewsel_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  dewsel_pkg::div_item_t item,
	output logic                  valid_out,
	input  logic                  stall_next,
	output dewsel_pkg::div_item_t item_out
);

	dewsel_pkg::div_item_t                  div_s [dewsel_pkg::DIV_STAGES];
	dewsel_pkg::div_item_t                  step  [dewsel_pkg::DIV_STAGES];
	logic [dewsel_pkg::DIV_STAGES-1:0]      vld_s;
	logic [dewsel_pkg::DIV_STAGES-1:0]      stl;

	function automatic dewsel_pkg::div_item_t div_steps(dewsel_pkg::div_item_t d);
		dewsel_pkg::div_item_t r;
		r = d;
		for (int i = 0; i < dewsel_pkg::NUM_CH; i++) begin
			for (int k = 0; k < dewsel_pkg::BITS_PER_STAGE; k++) begin
				if ({{(dewsel_pkg::DVS_W-dewsel_pkg::TIME_W){1'b0}}, r.rem[i]} >= r.dvs[i]) begin
					r.rem[i] = r.rem[i] - r.dvs[i][dewsel_pkg::TIME_W-1:0];
					r.q[i] = {r.q[i][dewsel_pkg::QUO_W-2:0], 1'b1};
				end else begin
					r.q[i] = {r.q[i][dewsel_pkg::QUO_W-2:0], 1'b0};
				end
				r.dvs[i] = r.dvs[i] >> 1;
			end
		end
		return r;
	endfunction

	assign stall = stl[0];
	assign valid_out = vld_s[dewsel_pkg::DIV_STAGES-1];
	assign item_out = div_s[dewsel_pkg::DIV_STAGES-1];

	for (genvar s = 0; s < dewsel_pkg::DIV_STAGES; s++) begin : g_stage
		logic                  vin;
		dewsel_pkg::div_item_t din;

		if (s == 0) begin : g_first
			assign vin = valid;
			assign din = item;
		end else begin : g_rest
			assign vin = vld_s[s-1];
			assign din = div_s[s-1];
		end

		if (s == dewsel_pkg::DIV_STAGES - 1) begin : g_last
			assign stl[s] = vld_s[s] & stall_next;
		end else begin : g_mid
			assign stl[s] = vld_s[s] & stl[s+1];
		end

		assign step[s] = div_steps(din);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[s] <= 1'b0;
			else if (!stl[s])
				vld_s[s] <= vin;
		end

		always_ff @(posedge clk) begin
			if (!stl[s] && vin)
				div_s[s] <= step[s];
		end
	end

endmodule

// ===== rtl/core/dewsel_combine.sv =====
module dewsel_combine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  dewsel_pkg::div_item_t item,
	input  dewsel_pkg::cfg_t      cfg,
	output logic                  valid_s7,
	input  logic                  stall_next,
	output logic                  accept_s7,
	output logic                  time_ok_s7,
	output logic                  amp_ok_s7,
	output logic                  outer_ok_s7,
	output logic                  delta_ok_s7,
	output logic signed [19:0]    delta_q_s7,
	output logic signed [18:0]    outer_diff_h_s7
);

	logic                     valid_s6;
	logic                     stall_s6;
	logic                     stall_s7;
	logic                     time_ok_s6;
	logic                     amp_ok_s6;
	logic signed [18:0]       od_s6;
	logic signed [19:0]       dq_s6;

	logic signed [16:0]       c [dewsel_pkg::NUM_CH];
	logic signed [17:0]       p1, p2, p3;
	logic signed [18:0]       od_w;
	logic signed [20:0]       dq_w;

	logic signed [19:0]       x;
	logic signed [19:0]       hw;
	logic signed [10:0]       off;
	logic signed [19:0]       dlow;
	logic signed [19:0]       dhigh;
	logic                     pre;
	logic                     outer_w;
	logic                     delta_w;

	assign stall_s7 = valid_s7 & stall_next;
	assign stall_s6 = valid_s6 & stall_s7;
	assign stall = stall_s6;

	always_comb begin
		for (int i = 0; i < dewsel_pkg::NUM_CH; i++)
			c[i] = signed'({1'b0, item.t[i]}) - signed'({9'd0, item.q[i]});
		p1 = 18'(c[0]) + 18'(c[3]);
		p2 = 18'(c[1]) + 18'(c[4]);
		p3 = 18'(c[2]) + 18'(c[5]);
		od_w = 19'(p1) - 19'(p3);
		dq_w = (21'(p2) <<< 1) - 21'(p1) - 21'(p3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s6 <= 1'b0;
		else if (!stall_s6)
			valid_s6 <= valid;
	end

	always_ff @(posedge clk) begin
		if (!stall_s6 && valid) begin
			time_ok_s6 <= item.time_ok;
			amp_ok_s6 <= item.amp_ok;
			od_s6 <= od_w;
			dq_s6 <= dq_w[19:0];
		end
	end

	always_comb begin
		off = cfg.outer_offset_h;
		dlow = cfg.delta_low_q;
		dhigh = cfg.delta_high_q;
		hw = signed'({10'd0, cfg.outer_halfwidth_h});
		x = 20'(od_s6) + 20'(off);
		pre = time_ok_s6 & amp_ok_s6;
		outer_w = pre & (x < hw) & (x > -hw);
		delta_w = pre & (dq_s6 > dlow) & (dq_s6 < dhigh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s7 <= 1'b0;
		else if (!stall_s7)
			valid_s7 <= valid_s6;
	end

	always_ff @(posedge clk) begin
		if (!stall_s7 && valid_s6) begin
			accept_s7 <= outer_w & delta_w;
			time_ok_s7 <= time_ok_s6;
			amp_ok_s7 <= amp_ok_s6;
			outer_ok_s7 <= outer_w;
			delta_ok_s7 <= delta_w;
			delta_q_s7 <= pre ? dq_s6 : '0;
			outer_diff_h_s7 <= pre ? od_s6 : '0;
		end
	end

endmodule

// ===== rtl/core/detector_event_time_walk_selector_unit.sv =====
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | time_a..time_f, amp_a..amp_f
// out      | output    | out_valid / out_stall| accept, flags, delta_q, outer_diff_h
// cfg      | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// One request enters per clock unless in_stall is high; each result is registered in turn
// by the check stage, a restoring divider for the walk quotient, two quotient bits per stage
// over four stages, and two arithmetic stages.
// Reset clears all stage valid bits and loads the register defaults.
// A stall on the output holds only the occupied stages; empty stages keep filling.
module detector_event_time_walk_selector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dewsel_pkg::ADDR_W-1:0] paddr,
	input  logic [dewsel_pkg::DATA_W-1:0] pwdata,
	output logic [dewsel_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [15:0]                   time_a,
	input  logic [15:0]                   time_b,
	input  logic [15:0]                   time_c,
	input  logic [15:0]                   time_d,
	input  logic [15:0]                   time_e,
	input  logic [15:0]                   time_f,
	input  logic [11:0]                   amp_a,
	input  logic [11:0]                   amp_b,
	input  logic [11:0]                   amp_c,
	input  logic [11:0]                   amp_d,
	input  logic [11:0]                   amp_e,
	input  logic [11:0]                   amp_f,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accept,
	output logic                          time_ok,
	output logic                          amp_ok,
	output logic                          outer_ok,
	output logic                          delta_ok,
	output logic signed [19:0]            delta_q,
	output logic signed [18:0]            outer_diff_h
);

	dewsel_pkg::cfg_t                                       cfg;
	dewsel_pkg::div_item_t                                  item_s1;
	dewsel_pkg::div_item_t                                  div_item;
	logic                                                   valid_s1;
	logic                                                   div_valid;
	logic                                                   div_stall;
	logic                                                   comb_stall;
	logic [dewsel_pkg::NUM_CH-1:0][dewsel_pkg::TIME_W-1:0]  t;
	logic [dewsel_pkg::NUM_CH-1:0][dewsel_pkg::AMP_W-1:0]   a;

	assign t = {time_f, time_e, time_d, time_c, time_b, time_a};
	assign a = {amp_f, amp_e, amp_d, amp_c, amp_b, amp_a};

	dewsel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dewsel_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (in_valid),
		.stall      (in_stall),
		.t          (t),
		.a          (a),
		.cfg        (cfg),
		.valid_s1   (valid_s1),
		.stall_next (div_stall),
		.item_s1    (item_s1)
	);

	dewsel_divider u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.stall      (div_stall),
		.item       (item_s1),
		.valid_out  (div_valid),
		.stall_next (comb_stall),
		.item_out   (div_item)
	);

	dewsel_combine u_combine (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid           (div_valid),
		.stall           (comb_stall),
		.item            (div_item),
		.cfg             (cfg),
		.valid_s7        (out_valid),
		.stall_next      (out_stall),
		.accept_s7       (accept),
		.time_ok_s7      (time_ok),
		.amp_ok_s7       (amp_ok),
		.outer_ok_s7     (outer_ok),
		.delta_ok_s7     (delta_ok),
		.delta_q_s7      (delta_q),
		.outer_diff_h_s7 (outer_diff_h)
	);

`ifndef SYNTH
	a_accept_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accept == (time_ok & amp_ok & outer_ok & delta_ok)))
		else $error("accept disagrees with check flags");

	a_precut_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !(time_ok && amp_ok)) |->
		(delta_q == '0 && outer_diff_h == '0 && !outer_ok && !delta_ok))
		else $error("derived values not cleared on precut failure");

	a_stall_origin: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");
`endif

endmodule
